>>> src/ebfs_pkg.sv
// Package for the e-book format sniffer: format codes and magic byte strings.
`default_nettype none
package ebfs_pkg;

	typedef enum logic [2:0] {
		FMT_UNKNOWN = 3'd0,
		FMT_MOBI    = 3'd1,
		FMT_AZW3    = 3'd2,
		FMT_DJVU    = 3'd3,
		FMT_FB2     = 3'd4
	} format_t;

	// One byte beat as it travels from the input stage to the tracker.
	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_last;
	} beat_t;

	localparam int unsigned WIN_DEPTH     = 10;
	localparam int unsigned AZW3_MIN_SIZE = 132;
	localparam int unsigned MIN_SIZE      = 8;

	localparam logic [7:0] MOBI_TAG [8] = '{8'h42, 8'h4F, 8'h4F, 8'h4B,
		8'h4D, 8'h4F, 8'h42, 8'h49};
	localparam logic [7:0] DJVU_TAG [8] = '{8'h41, 8'h54, 8'h26, 8'h54,
		8'h46, 8'h4F, 8'h52, 8'h4D};
	localparam logic [7:0] XML_TAG  [5] = '{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C};
	// "FictionBook", first character first
	localparam logic [7:0] FB_TAG   [11] = '{8'h46, 8'h69, 8'h63, 8'h74,
		8'h69, 8'h6F, 8'h6E, 8'h42, 8'h6F, 8'h6F, 8'h6B};
	// "KF8"
	localparam logic [7:0] KF8_TAG  [3] = '{8'h4B, 8'h46, 8'h38};

endpackage
`default_nettype wire

>>> src/ebfs_track.sv
// Per-file tracker: position counter, byte window, match flags and the decision.
`default_nettype none
module ebfs_track
	import ebfs_pkg::*;
#(
	parameter int unsigned SEARCH_LIMIT = 1024,
	parameter int unsigned MOBI_OFFSET  = 60
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire beat_t   beat,
	input  wire logic    step,
	output format_t      code
);

	localparam int unsigned POS_SAT = SEARCH_LIMIT + MOBI_OFFSET + 256;
	localparam int unsigned PW      = $clog2(POS_SAT + 1);

	localparam logic [PW-1:0] P_SAT     = PW'(POS_SAT);
	localparam logic [PW-1:0] P_MO      = PW'(MOBI_OFFSET);
	localparam logic [PW-1:0] P_MO_END  = PW'(MOBI_OFFSET + 8);
	localparam logic [PW-1:0] P_MO_SIZE = PW'(MOBI_OFFSET + 7);
	localparam logic [PW-1:0] P_LIMIT   = PW'(SEARCH_LIMIT);
	localparam logic [PW-1:0] P_AZW3    = PW'(AZW3_MIN_SIZE - 1);
	localparam logic [PW-1:0] P_SHORT   = PW'(MIN_SIZE - 1);
	localparam logic [PW-1:0] P_DJVU    = PW'(8);
	localparam logic [PW-1:0] P_XML     = PW'(5);
	localparam logic [PW-1:0] P_KF8     = PW'(2);
	localparam logic [PW-1:0] P_FB      = PW'(10);

	logic [PW-1:0] pos_q;
	logic [7:0]    win_q [WIN_DEPTH];
	logic          mobi_q, djvu_q, xml_q, kf8_q, fb_q;

	logic [2:0]    mo_rel;
	logic          mobi_d, djvu_d, xml_d, kf8_d, fb_d;
	logic          kf8_hit, fb_hit;
	logic [7:0]    b;

	assign b      = beat.byte_value;
	// Offset inside the MOBI tag; only used while the position is inside it.
	assign mo_rel = pos_q[2:0] - P_MO[2:0];

	always_comb begin
		kf8_hit = (b == KF8_TAG[2]) && (win_q[0] == KF8_TAG[1]) && (win_q[1] == KF8_TAG[0]);
		fb_hit  = (b == FB_TAG[10]);
		for (int i = 0; i < 10; i++) begin
			if (win_q[i] != FB_TAG[9 - i]) begin
				fb_hit = 1'b0;
			end
		end
	end

	always_comb begin
		mobi_d = mobi_q;
		djvu_d = djvu_q;
		xml_d  = xml_q;
		kf8_d  = kf8_q;
		fb_d   = fb_q;
		if (pos_q >= P_MO && pos_q < P_MO_END && b != MOBI_TAG[mo_rel]) begin
			mobi_d = 1'b0;
		end
		if (pos_q < P_DJVU && b != DJVU_TAG[pos_q[2:0]]) begin
			djvu_d = 1'b0;
		end
		if (pos_q < P_XML && b != XML_TAG[pos_q[2:0]]) begin
			xml_d = 1'b0;
		end
		if (pos_q >= P_KF8 && kf8_hit) begin
			kf8_d = 1'b1;
		end
		if (pos_q >= P_FB && pos_q < P_LIMIT && fb_hit) begin
			fb_d = 1'b1;
		end
	end

	// Decide on the flags as updated by the current byte.
	always_comb begin
		if (pos_q < P_SHORT) begin
			code = FMT_UNKNOWN;
		end else if (pos_q >= P_MO_SIZE && mobi_d) begin
			code = (pos_q >= P_AZW3 && kf8_d) ? FMT_AZW3 : FMT_MOBI;
		end else if (djvu_d) begin
			code = FMT_DJVU;
		end else if (xml_d && fb_d) begin
			code = FMT_FB2;
		end else begin
			code = FMT_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mobi_q <= 1'b1;
			djvu_q <= 1'b1;
			xml_q  <= 1'b1;
			kf8_q  <= 1'b0;
			fb_q   <= 1'b0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (step) begin
			if (beat.is_last) begin
				pos_q  <= '0;
				mobi_q <= 1'b1;
				djvu_q <= 1'b1;
				xml_q  <= 1'b1;
				kf8_q  <= 1'b0;
				fb_q   <= 1'b0;
				for (int i = 0; i < WIN_DEPTH; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				if (pos_q < P_SAT) begin
					pos_q <= pos_q + PW'(1);
				end
				mobi_q   <= mobi_d;
				djvu_q   <= djvu_d;
				xml_q    <= xml_d;
				kf8_q    <= kf8_d;
				fb_q     <= fb_d;
				win_q[0] <= b;
				for (int i = 1; i < WIN_DEPTH; i++) begin
					win_q[i] <= win_q[i - 1];
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> src/ebook_format_sniffer.sv
// A byte beat is first captured in the input register and then steps the tracker; on the
// last byte the format code is loaded into the output register and shown from there.
// Throughput: one byte per cycle, also while a result waits; the only stall is
// a last byte held in the input register while the output register is full.
// Reset (arst_n low): both registers empty, tracker at the start of a file.
`default_nettype none
module ebook_format_sniffer
	import ebfs_pkg::*;
#(
	parameter int unsigned SEARCH_LIMIT = 1024,
	parameter int unsigned MOBI_OFFSET  = 60
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [7:0] byte_value,
	input  wire logic       is_last,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [2:0]      format_code
);

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	// Output register
	logic       out_valid_q;
	format_t    code_q;

	beat_t      beat_s1;
	format_t    code;
	logic       out_free;
	logic       s1_go;

	// Output register frees up this cycle if empty or being taken.
	assign out_free = !out_valid_q || result_ready;
	// A middle byte never needs the output side; a last byte waits for room.
	assign s1_go      = valid_s1 && (!last_s1 || out_free);
	assign item_ready = !valid_s1 || s1_go;

	assign beat_s1 = '{byte_value: byte_s1, is_last: last_s1};

	ebfs_track #(
		.SEARCH_LIMIT(SEARCH_LIMIT),
		.MOBI_OFFSET (MOBI_OFFSET)
	) u_track (
		.clk   (clk),
		.arst_n(arst_n),
		.beat  (beat_s1),
		.step  (s1_go),
		.code  (code)
	);

	// Hold the input beat until the tracker takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			byte_s1 <= byte_value;
			last_s1 <= is_last;
		end
	end

	// Load the result on a last byte; drop it once the consumer takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			code_q <= code;
		end
	end

	assign result_valid = out_valid_q;
	assign format_code  = code_q;

endmodule
`default_nettype wire

>>> sim/tb_ebook_format_sniffer.sv
// Self-checking testbench for the e-book format sniffer: directed files, then random files.
`timescale 1ns / 100ps
module tb_ebook_format_sniffer;
	import ebfs_pkg::*;

	localparam int SEARCH_LIMIT  = 1024;
	localparam int MOBI_OFFSET   = 60;
	localparam int POS_CAP       = SEARCH_LIMIT + MOBI_OFFSET + 256;
	localparam int AZW3_SIZE     = 132;
	localparam int SHORT_SIZE    = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_BYTES  = 420;
	localparam int RANDOM_FILES  = 8;

	// Magic strings, right aligned, first character in the highest byte.
	localparam logic [87:0] MOBI_MAGIC = "BOOKMOBI";
	localparam logic [87:0] DJVU_MAGIC = "AT&TFORM";
	localparam logic [87:0] XML_MAGIC  = "<?xml";
	localparam logic [87:0] FB_WORD    = "FictionBook";
	localparam logic [87:0] KF8_WORD   = "KF8";
	// Letters of every tag, mixed into file content so partial matches happen often.
	localparam int ALPHA_LEN = 35;
	localparam logic [8*ALPHA_LEN-1:0] TAG_LETTERS = "BOOKMOBIAT&TFORM<?xmlFictionBookKF8";

	typedef enum int {
		SHAPE_FLAT,
		SHAPE_NOISE,
		SHAPE_MOBI,
		SHAPE_AZW3,
		SHAPE_DJVU,
		SHAPE_MOBI_DJVU,
		SHAPE_FB2
	} file_shape_t;

	// aux: fill byte for a flat file, KF8 offset for AZW3, FictionBook offset for FB2
	// (-1 leaves it out or places it at random). flip: byte index to damage, -1 for none.
	typedef struct packed {
		file_shape_t shape;
		int          len;
		int          aux;
		int          flip;
		bit          pinned;
		format_t     code;
	} file_case_t;

	file_case_t directed_files [0:14] = '{
		'{SHAPE_FLAT,         1, 8'h00,   -1, 1'b1, FMT_UNKNOWN},
		'{SHAPE_FLAT,         1, 8'hFF,   -1, 1'b1, FMT_UNKNOWN},
		'{SHAPE_FLAT,         8, 8'h00,   -1, 1'b1, FMT_UNKNOWN},
		'{SHAPE_FLAT,        12, 8'hFF,   -1, 1'b1, FMT_UNKNOWN},
		'{SHAPE_DJVU,         7,    -1,   -1, 1'b1, FMT_UNKNOWN},
		'{SHAPE_DJVU,         8,    -1,   -1, 1'b1, FMT_DJVU},
		'{SHAPE_DJVU,        12,    -1,    7, 1'b1, FMT_UNKNOWN},
		'{SHAPE_MOBI,        67,    -1,   -1, 1'b0, FMT_UNKNOWN},
		'{SHAPE_MOBI,        68,    -1,   -1, 1'b1, FMT_MOBI},
		'{SHAPE_AZW3,       131,   128,   -1, 1'b1, FMT_MOBI},
		'{SHAPE_AZW3,       132,   129,   -1, 1'b1, FMT_AZW3},
		'{SHAPE_MOBI,        70,    -1,   67, 1'b0, FMT_UNKNOWN},
		'{SHAPE_MOBI_DJVU,   68,    -1,   -1, 1'b1, FMT_MOBI},
		'{SHAPE_FB2,         24,     5,   -1, 1'b1, FMT_FB2},
		'{SHAPE_FB2,         24,    12,    2, 1'b0, FMT_UNKNOWN}
	};

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic [7:0] byte_value   = 8'h00;
	logic       is_last      = 1'b0;
	logic       result_ready = 1'b0;
	logic       item_ready;
	logic       result_valid;
	logic [2:0] format_code;

	// Tracker copy: bytes seen before the current one and the flags built so far.
	int          pos_count;
	logic [79:0] recent;
	bit          mobi_hold, djvu_hold, xml_hold, kf8_found, fb_found;

	format_t     expected_codes [$];
	logic [7:0]  file_buf [$];
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int          errors;
	int          bytes_sent, files_sent, rand_bytes, rand_files, results_seen;
	int          fmt_tally [5];

	ebook_format_sniffer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.byte_value  (byte_value),
		.is_last     (is_last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.format_code (format_code)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void restart_file();
		pos_count = 0;
		recent    = '0;
		mobi_hold = 1'b1;
		djvu_hold = 1'b1;
		xml_hold  = 1'b1;
		kf8_found = 1'b0;
		fb_found  = 1'b0;
	endfunction

	// Advance the tracker by one byte; return 1 with the format code on the last byte.
	function automatic bit sniff_byte(input logic [7:0] b, input bit last,
			output format_t code);
		int p;
		int fsize;
		p = pos_count;
		code = FMT_UNKNOWN;
		if (p >= MOBI_OFFSET && p < MOBI_OFFSET + 8
				&& b != MOBI_MAGIC[8*(MOBI_OFFSET+7-p) +: 8])
			mobi_hold = 1'b0;
		if (p < 8 && b != DJVU_MAGIC[8*(7-p) +: 8])
			djvu_hold = 1'b0;
		if (p < 5 && b != XML_MAGIC[8*(4-p) +: 8])
			xml_hold = 1'b0;
		if (p >= 2 && {recent[15:0], b} == KF8_WORD[23:0])
			kf8_found = 1'b1;
		// FictionBook must end inside the search window
		if (p >= 10 && p < SEARCH_LIMIT && {recent, b} == FB_WORD)
			fb_found = 1'b1;
		recent = {recent[71:0], b};
		if (pos_count < POS_CAP)
			pos_count++;
		if (!last)
			return 1'b0;
		fsize = p + 1;
		if (fsize < SHORT_SIZE)
			code = FMT_UNKNOWN;
		else if (fsize >= MOBI_OFFSET + 8 && mobi_hold)
			code = (fsize >= AZW3_SIZE && kf8_found) ? FMT_AZW3 : FMT_MOBI;
		else if (djvu_hold)
			code = FMT_DJVU;
		else if (xml_hold && fb_found)
			code = FMT_FB2;
		restart_file();
		return 1'b1;
	endfunction

	// Half raw bytes, half tag letters.
	function automatic logic [7:0] pick_byte();
		int k;
		k = $urandom_range(0, 2 * ALPHA_LEN - 1);
		if (k >= ALPHA_LEN)
			return 8'($urandom_range(0, 255));
		return TAG_LETTERS[8*k +: 8];
	endfunction

	// Overwrite the file at an offset with a tag, clipped at the end of the file.
	function automatic void put_word(input int at, input logic [87:0] word, input int n);
		for (int i = 0; i < n; i++) begin
			if (at + i < file_buf.size())
				file_buf[at + i] = word[8*(n-1-i) +: 8];
		end
	endfunction

	function automatic void build_file(input file_shape_t shape, input int len, input int aux,
			input int flip);
		int at;
		file_buf.delete();
		for (int i = 0; i < len; i++)
			file_buf.push_back(shape == SHAPE_FLAT ? aux[7:0] : pick_byte());
		if (shape == SHAPE_DJVU || shape == SHAPE_MOBI_DJVU)
			put_word(0, DJVU_MAGIC, 8);
		if (shape == SHAPE_MOBI || shape == SHAPE_AZW3 || shape == SHAPE_MOBI_DJVU)
			put_word(MOBI_OFFSET, MOBI_MAGIC, 8);
		if (shape == SHAPE_AZW3) begin
			// keep a random KF8 clear of the MOBI tag, before or after it
			if (aux >= 0)
				at = aux;
			else if ($urandom_range(0, 1) == 0)
				at = $urandom_range(0, MOBI_OFFSET - 3);
			else
				at = $urandom_range(MOBI_OFFSET + 8, len - 3);
			put_word(at, KF8_WORD, 3);
		end
		if (shape == SHAPE_FB2) begin
			put_word(0, XML_MAGIC, 5);
			if (aux >= 0)
				put_word(aux, FB_WORD, 11);
		end
		if (flip >= 0 && flip < len)
			file_buf[flip] ^= 8'h01 << $urandom_range(0, 7);
	endfunction

	// Stream the file in file_buf; the expectation goes in when the last byte is taken.
	task automatic send_file(input bit pinned, input format_t pin_code);
		format_t code;
		int gap;
		for (int i = 0; i < file_buf.size(); i++) begin
			gap = tx_idle ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			item_valid <= 1'b1;
			byte_value <= file_buf[i];
			is_last    <= (i == file_buf.size() - 1);
			@(posedge clk);
			while (!item_ready)
				@(posedge clk);
			bytes_sent++;
			if (sniff_byte(file_buf[i], i == file_buf.size() - 1, code))
				expected_codes.push_back(pinned ? pin_code : code);
		end
		files_sent++;
		if ($urandom_range(0, 3) == 0)
			tx_idle = !tx_idle;
	endtask

	// Hold the sender off until every outstanding code has come back.
	task automatic wait_drained();
		if (expected_codes.size() != 0) begin
			item_valid <= 1'b0;
			while (expected_codes.size() != 0)
				@(posedge clk);
		end
	endtask

	// Stimulus: reset, directed table, random files, drain, verdict.
	initial begin
		file_case_t fc;
		file_shape_t shape;
		int len, aux, flip, lo, hi, r;
		restart_file();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed files: pinned rows carry a hand-written code, the rest use the tracker.
		foreach (directed_files[k]) begin
			fc = directed_files[k];
			build_file(fc.shape, fc.len, fc.aux, fc.flip);
			send_file(fc.pinned, fc.code);
		end
		wait_drained();

		// Random files: mostly well-formed headers with random content, some noise and damage.
		while (rand_bytes < RANDOM_BYTES || rand_files < RANDOM_FILES) begin
			r   = $urandom_range(0, 99);
			aux = -1;
			lo  = 0;
			hi  = 0;
			if (r < 15) begin
				shape = SHAPE_NOISE;
				len   = $urandom_range(1, 24);
				hi    = len - 1;
			end else if (r < 25) begin
				shape = SHAPE_MOBI;
				len   = $urandom_range(60, 80);
				lo    = MOBI_OFFSET;
				hi    = MOBI_OFFSET + 7;
			end else if (r < 35) begin
				shape = SHAPE_AZW3;
				len   = $urandom_range(120, 140);
				lo    = MOBI_OFFSET;
				hi    = MOBI_OFFSET + 7;
			end else if (r < 55) begin
				shape = SHAPE_DJVU;
				len   = $urandom_range(1, 30);
				hi    = 7;
			end else if (r < 60) begin
				shape = SHAPE_MOBI_DJVU;
				len   = $urandom_range(60, 75);
				hi    = MOBI_OFFSET + 7;
			end else begin
				shape = SHAPE_FB2;
				hi    = 4;
				len   = $urandom_range(10, 40);
				if (len >= 16 && $urandom_range(0, 5) != 0)
					aux = $urandom_range(5, len - 11);
			end
			flip = ($urandom_range(0, 4) == 0) ? $urandom_range(lo, hi) : -1;
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			build_file(shape, len, aux, flip);
			send_file(1'b0, FMT_UNKNOWN);
			rand_bytes += len;
			rand_files++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d files (%0d bytes), %0d format codes checked.",
			files_sent, bytes_sent, results_seen);
		$display("Codes: unknown %0d, MOBI %0d, AZW3 %0d, DjVu %0d, FB2 %0d.",
			fmt_tally[0], fmt_tally[1], fmt_tally[2], fmt_tally[3], fmt_tally[4]);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: draw a stall per code, then compare against the oldest expectation.
	initial begin
		int gap;
		format_t want;
		wait (arst_n);
		forever begin
			gap = rx_idle ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			if (expected_codes.size() == 0) begin
				$error("format_code: no result expected, actual %0d", format_code);
				errors++;
			end else begin
				want = expected_codes.pop_front();
				results_seen++;
				fmt_tally[int'(want)]++;
				if (format_code !== want) begin
					$error("format_code: expected %0d, actual %0d", want, format_code);
					errors++;
				end
			end
			if ($urandom_range(0, 15) == 0)
				rx_idle = !rx_idle;
		end
	end

	// Watchdog: drop the run when no beat moves on either channel for too long.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$error("no beat accepted for %0d cycles, %0d codes outstanding",
			STALL_LIMIT, expected_codes.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
